>>> rtl/cdm_pkg.sv
// Shared types and constants for the concentric disk map unit.
// No dependencies; imported by every module under rtl.
`timescale 1ns / 1ps

package cdm_pkg;

	// Per-stage control carried along the cell chain
	typedef struct packed {
		logic valid;
	} cdm_ctl_t;

	localparam int MAX_ITERS  = 28;
	localparam int GUARD_BITS = 8;
	localparam int ANGLE_W    = 32;

	// CORDIC start gain, 1/K in Q30
	localparam logic [29:0] GAIN_Q30 = 30'd652032874;

	// Arctangent of 2^-i, binary angle with 2^32 units per turn
	localparam logic [ANGLE_W-1:0] ATAN_TAB [MAX_ITERS] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5
	};

	// Quarter-turn codes applied after the CORDIC
	typedef enum logic [1:0] {
		QTR_0   = 2'd0,
		QTR_90  = 2'd1,
		QTR_180 = 2'd2,
		QTR_270 = 2'd3
	} cdm_qtr_t;

endpackage

>>> rtl/concentric_disk_map_unit.sv
// Concentric square-to-disk map: top level with sector, divider, CORDIC and output stages.
// Depends on cdm_pkg, cdm_div_cell and cdm_cordic_cell.
`timescale 1ns / 1ps

// Maps each point (u, v) of the unit square, unsigned Q0.FRAC_BITS, onto the unit disk
// with the concentric (equal-area) mapping and returns (x, y) in signed Q1.FRAC_BITS.
// The square centre maps to the origin. One word is accepted per clock unless the row is
// stalled. A word passes through the sector register, the row of one-bit divider cells
// (FRAC_BITS + 1 of them), the angle and gain register, the row of CORDIC cells and the output register. The whole
// row advances together: it stalls only while a finished word waits at the output and
// m_tready is low, so the next word is taken whenever the output register is free or is
// being emptied in the same cycle.
module concentric_disk_map_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [((2*FRAC_BITS+7)/8)*8-1:0]    s_tdata,  // square_u, square_v
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [((2*FRAC_BITS+11)/8)*8-1:0]   m_tdata   // disk_x, disk_y
);
	import cdm_pkg::*;

	localparam int F      = FRAC_BITS;
	localparam int OUT_W  = ((2*F+11)/8)*8;
	localparam int NITER  = (F + 4 < MAX_ITERS) ? F + 4 : MAX_ITERS;
	localparam int XW     = F + 11;
	localparam int SIDE_W = F + 5;   // {r, zero, off, sign}
	localparam int NDIV   = F + 1;

	logic en;

	// advance the whole row unless a finished word is held back
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---------------- sector stage ----------------
	logic [F-1:0]          sq_u;
	logic [F-1:0]          sq_v;
	logic signed [F+1:0]   px;
	logic signed [F+1:0]   py;
	logic [F:0]            abs_px;
	logic [F:0]            abs_py;
	logic [F:0]            a_c;
	logic [F:0]            b_c;
	logic                  neg_c;
	logic                  sub_c;
	logic [1:0]            off_c;
	logic                  zero_c;
	logic [2*F+1:0]        numer_c;

	assign sq_u   = s_tdata[F-1:0];
	assign sq_v   = s_tdata[2*F-1:F];
	assign px     = $signed({1'b0, sq_u, 1'b0}) - $signed((F+2)'(1) << F);
	assign py     = $signed({1'b0, sq_v, 1'b0}) - $signed((F+2)'(1) << F);
	assign abs_px = px[F+1] ? (F+1)'(-px) : (F+1)'(px);
	assign abs_py = py[F+1] ? (F+1)'(-py) : (F+1)'(py);

	// pick the sector by comparing px with py and -py
	always_comb begin
		zero_c = 1'b0;
		if (px > -py) begin
			if (px > py) begin
				a_c = abs_py; b_c = abs_px; neg_c = py[F+1];  sub_c = 1'b0; off_c = 2'd0;
			end else begin
				a_c = abs_px; b_c = abs_py; neg_c = px[F+1];  sub_c = 1'b1; off_c = 2'd1;
			end
		end else begin
			if (px < py) begin
				a_c = abs_py; b_c = abs_px; neg_c = !py[F+1]; sub_c = 1'b0; off_c = 2'd2;
			end else begin
				a_c = abs_px; b_c = abs_py; neg_c = !px[F+1]; sub_c = 1'b1; off_c = 2'd3;
				zero_c = (py == '0);
			end
		end
	end

	// numerator with the rounding half folded in
	assign numer_c = ({1'b0, a_c, {F{1'b0}}}) + (2*F+2)'(b_c >> 1);

	cdm_ctl_t           ctl_s1;
	logic [F:0]         rem_s1;
	logic [F:0]         low_s1;
	logic [F:0]         den_s1;
	logic [SIDE_W-1:0]  side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1.valid <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1  <= numer_c[2*F+1:F+1];
			low_s1  <= numer_c[F:0];
			den_s1  <= b_c;
			side_s1 <= {b_c, zero_c, off_c, neg_c ^ sub_c};
		end
	end

	// ---------------- divider row ----------------
	cdm_ctl_t           d_ctl  [NDIV+1];
	logic [F:0]         d_rem  [NDIV+1];
	logic [F:0]         d_low  [NDIV+1];
	logic [F:0]         d_quo  [NDIV+1];
	logic [F:0]         d_den  [NDIV+1];
	logic [SIDE_W-1:0]  d_side [NDIV+1];

	assign d_ctl[0]  = ctl_s1;
	assign d_rem[0]  = rem_s1;
	assign d_low[0]  = low_s1;
	assign d_quo[0]  = '0;
	assign d_den[0]  = den_s1;
	assign d_side[0] = side_s1;

	for (genvar k = 0; k < NDIV; k++) begin : g_div
		cdm_div_cell #(.FRAC_BITS(F), .SIDE_W(SIDE_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ctl_in  (d_ctl[k]),
			.rem_in  (d_rem[k]),
			.low_in  (d_low[k]),
			.quo_in  (d_quo[k]),
			.den_in  (d_den[k]),
			.side_in (d_side[k]),
			.ctl_out (d_ctl[k+1]),
			.rem_out (d_rem[k+1]),
			.low_out (d_low[k+1]),
			.quo_out (d_quo[k+1]),
			.den_out (d_den[k+1]),
			.side_out(d_side[k+1])
		);
	end

	// ---------------- angle and gain stage ----------------
	logic [F:0]            quo_f;
	logic [F:0]            r_f;
	logic                  zero_f;
	logic [1:0]            off_f;
	logic                  sign_f;
	logic signed [F+3:0]   ratio_f;
	logic signed [F+3:0]   phi_f;
	logic [F+3:0]          phi_p1;
	logic signed [F+1:0]   res_f;
	logic [F+30:0]         prod_f;

	assign quo_f = d_quo[NDIV];
	assign {r_f, zero_f, off_f, sign_f} = d_side[NDIV];
	assign ratio_f = sign_f ? -$signed({3'b0, quo_f}) : $signed({3'b0, quo_f});
	assign phi_f   = zero_f ? '0 : $signed({1'b0, off_f, {(F+1){1'b0}}}) + ratio_f;
	assign phi_p1  = phi_f + $signed((F+4)'(1) << F);
	// residual in [-1, 1) pi/4 units around the chosen quarter turn
	assign res_f   = $signed({1'b0, phi_p1[F:0]}) - $signed((F+2)'(1) << F);
	assign prod_f  = (F+31)'(r_f) * (F+31)'(GAIN_Q30)
	               + (F+31)'(1 << (29 - GUARD_BITS));

	cdm_ctl_t              ctl_s2;
	logic signed [XW-1:0]  x_s2;
	logic signed [31:0]    z_s2;
	logic [1:0]            qtr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= d_ctl[NDIV];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2   <= $signed({2'b0, prod_f[F+30:30-GUARD_BITS]});
			z_s2   <= 32'(res_f) <<< (29 - F);
			qtr_s2 <= phi_p1[F+2:F+1];
		end
	end

	// ---------------- CORDIC row ----------------
	cdm_ctl_t              c_ctl [NITER+1];
	logic signed [XW-1:0]  c_x   [NITER+1];
	logic signed [XW-1:0]  c_y   [NITER+1];
	logic signed [31:0]    c_z   [NITER+1];
	logic [1:0]            c_qtr [NITER+1];

	assign c_ctl[0] = ctl_s2;
	assign c_x[0]   = x_s2;
	assign c_y[0]   = '0;
	assign c_z[0]   = z_s2;
	assign c_qtr[0] = qtr_s2;

	for (genvar i = 0; i < NITER; i++) begin : g_cordic
		cdm_cordic_cell #(.ITER(i), .XW(XW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_in (c_ctl[i]),
			.x_in   (c_x[i]),
			.y_in   (c_y[i]),
			.z_in   (c_z[i]),
			.qtr_in (c_qtr[i]),
			.ctl_out(c_ctl[i+1]),
			.x_out  (c_x[i+1]),
			.y_out  (c_y[i+1]),
			.z_out  (c_z[i+1]),
			.qtr_out(c_qtr[i+1])
		);
	end

	// ---------------- quarter turn, round and saturate ----------------
	logic signed [XW-1:0]  xr;
	logic signed [XW-1:0]  yr;
	logic signed [XW-1:0]  xt;
	logic signed [XW-1:0]  yt;
	logic signed [F+2:0]   xs;
	logic signed [F+2:0]   ys;
	logic signed [F+1:0]   xo;
	logic signed [F+1:0]   yo;

	always_comb begin
		unique case (cdm_qtr_t'(c_qtr[NITER]))
			QTR_90:  begin xr = -c_y[NITER]; yr =  c_x[NITER]; end
			QTR_180: begin xr = -c_x[NITER]; yr = -c_y[NITER]; end
			QTR_270: begin xr =  c_y[NITER]; yr = -c_x[NITER]; end
			default: begin xr =  c_x[NITER]; yr =  c_y[NITER]; end
		endcase
	end

	assign xt = (xr + $signed(XW'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
	assign yt = (yr + $signed(XW'(1) << (GUARD_BITS - 1))) >>> GUARD_BITS;
	assign xs = xt[F+2:0];
	assign ys = yt[F+2:0];

	// clamp to plus or minus one
	always_comb begin
		if (xs > $signed((F+3)'(1) << F))
			xo = $signed((F+2)'(1) << F);
		else if (xs < -$signed((F+3)'(1) << F))
			xo = -$signed((F+2)'(1) << F);
		else
			xo = xs[F+1:0];
		if (ys > $signed((F+3)'(1) << F))
			yo = $signed((F+2)'(1) << F);
		else if (ys < -$signed((F+3)'(1) << F))
			yo = -$signed((F+2)'(1) << F);
		else
			yo = ys[F+1:0];
	end

	logic               out_valid_q;
	logic [2*F+3:0]     out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c_ctl[NITER].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= {yo, xo};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);

	// ---------------- checks ----------------
	logic signed [F+1:0] chk_x;
	logic signed [F+1:0] chk_y;

	assign chk_x = out_data_q[F+1:0];
	assign chk_y = out_data_q[2*F+3:F+2];

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (chk_x <= $signed((F+2)'(1) << F)) && (chk_x >= -$signed((F+2)'(1) << F)))
		else $error("disk_x out of range");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (chk_y <= $signed((F+2)'(1) << F)) && (chk_y >= -$signed((F+2)'(1) << F)))
		else $error("disk_y out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input held back without a waiting result");

	a_last_cell_out: assert property (@(posedge clk) disable iff (!arst_n)
		(en && c_ctl[NITER].valid) |=> m_tvalid)
		else $error("result lost between CORDIC row and output");

endmodule

>>> rtl/cdm_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle while en is high.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_div_cell #(
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 21
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  cdm_pkg::cdm_ctl_t      ctl_in,
	input  logic [FRAC_BITS:0]     rem_in,
	input  logic [FRAC_BITS:0]     low_in,
	input  logic [FRAC_BITS:0]     quo_in,
	input  logic [FRAC_BITS:0]     den_in,
	input  logic [SIDE_W-1:0]      side_in,
	output cdm_pkg::cdm_ctl_t      ctl_out,
	output logic [FRAC_BITS:0]     rem_out,
	output logic [FRAC_BITS:0]     low_out,
	output logic [FRAC_BITS:0]     quo_out,
	output logic [FRAC_BITS:0]     den_out,
	output logic [SIDE_W-1:0]      side_out
);
	import cdm_pkg::*;

	logic [FRAC_BITS+1:0] trial;
	logic [FRAC_BITS+1:0] diff;
	logic                 take;

	// bring down the next numerator bit and try the subtract
	assign trial = {rem_in, low_in[FRAC_BITS]};
	assign diff  = trial - {1'b0, den_in};
	assign take  = trial >= {1'b0, den_in};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= take ? diff[FRAC_BITS:0] : trial[FRAC_BITS:0];
			low_out  <= {low_in[FRAC_BITS-1:0], 1'b0};
			quo_out  <= {quo_in[FRAC_BITS-1:0], take};
			den_out  <= den_in;
			side_out <= side_in;
		end
	end

endmodule

>>> rtl/cdm_cordic_cell.sv
// One CORDIC rotation cell with a fixed shift and arctangent constant.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_cordic_cell #(
	parameter int ITER = 0,
	parameter int XW   = 27
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       en,
	input  cdm_pkg::cdm_ctl_t          ctl_in,
	input  logic signed [XW-1:0]       x_in,
	input  logic signed [XW-1:0]       y_in,
	input  logic signed [31:0]         z_in,
	input  logic [1:0]                 qtr_in,
	output cdm_pkg::cdm_ctl_t          ctl_out,
	output logic signed [XW-1:0]       x_out,
	output logic signed [XW-1:0]       y_out,
	output logic signed [31:0]         z_out,
	output logic [1:0]                 qtr_out
);
	import cdm_pkg::*;

	localparam logic signed [31:0] ATAN_C = $signed(ATAN_TAB[ITER]);

	logic signed [XW-1:0] dx;
	logic signed [XW-1:0] dy;

	assign dx = y_in >>> ITER;
	assign dy = x_in >>> ITER;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else if (en) begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!z_in[31]) begin
				x_out <= x_in - dx;
				y_out <= y_in + dy;
				z_out <= z_in - ATAN_C;
			end else begin
				x_out <= x_in + dx;
				y_out <= y_in - dy;
				z_out <= z_in + ATAN_C;
			end
			qtr_out <= qtr_in;
		end
	end

endmodule

>>> sim/concentric_disk_map_checker.sv
// Checker for the concentric disk map unit: watches both stream channels,
// predicts each output word from the input word and compares field by field.
// Depends on cdm_pkg for the CORDIC constants and quarter-turn codes.
`timescale 1ns / 1ps

module concentric_disk_map_checker #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	input  logic [((2*FRAC_BITS+7)/8)*8-1:0]    s_tdata,  // square_u, square_v
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic [((2*FRAC_BITS+11)/8)*8-1:0]   m_tdata,  // disk_x, disk_y
	output int                                  fail_count,
	output int                                  pending
);
	import cdm_pkg::*;

	localparam int OW = FRAC_BITS + 2;

	typedef struct packed {
		logic signed [OW-1:0] y;
		logic signed [OW-1:0] x;
	} disk_pt_t;

	disk_pt_t expected_pts[$];

	// Rounded quotient of magnitudes, sign of the quotient applied afterwards
	function automatic longint sector_ratio(longint num, longint den);
		longint a, b, q;
		a = (num < 0 ? -num : num) <<< FRAC_BITS;
		b = den < 0 ? -den : den;
		if (b == 0)
			return 0;
		q = (a + b / 2) / b;
		return ((num < 0) != (den < 0)) ? -q : q;
	endfunction

	function automatic longint round_sat(longint v);
		longint one, r;
		one = longint'(1) <<< FRAC_BITS;
		r = (v + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
		if (r > one) r = one;
		if (r < -one) r = -one;
		return r;
	endfunction

	function automatic disk_pt_t map_to_disk(logic [FRAC_BITS-1:0] u, logic [FRAC_BITS-1:0] v);
		longint one, px, py, r, phi, res, x, y, z, dx, dy, t;
		int iters;
		cdm_qtr_t qtr;
		disk_pt_t p;
		one = longint'(1) <<< FRAC_BITS;
		px = 2 * longint'(u) - one;
		py = 2 * longint'(v) - one;
		iters = (FRAC_BITS + 4 < MAX_ITERS) ? FRAC_BITS + 4 : MAX_ITERS;
		if (px > -py) begin
			if (px > py) begin
				r = px;
				phi = sector_ratio(py, px);
			end else begin
				r = py;
				phi = 2 * one - sector_ratio(px, py);
			end
		end else begin
			if (px < py) begin
				r = -px;
				phi = 4 * one + sector_ratio(py, px);
			end else begin
				r = -py;
				phi = (py != 0) ? 6 * one - sector_ratio(px, py) : 0;
			end
		end
		t = (phi + one) >>> (FRAC_BITS + 1);
		qtr = cdm_qtr_t'(t[1:0]);
		res = phi - t * 2 * one;
		z = res <<< (29 - FRAC_BITS);
		x = (r * longint'(GAIN_Q30) + (longint'(1) <<< (29 - GUARD_BITS))) >>> (30 - GUARD_BITS);
		y = 0;
		for (int i = 0; i < iters; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
			end
		end
		case (qtr)
			QTR_90:  begin t = x; x = -y; y = t; end
			QTR_180: begin x = -x; y = -y; end
			QTR_270: begin t = x; x = y; y = -t; end
			default: ;
		endcase
		p.x = OW'(round_sat(x));
		p.y = OW'(round_sat(y));
		return p;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
		fail_count++;
	endtask

	assign pending = expected_pts.size();

	always @(posedge clk) begin
		disk_pt_t got, want;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_pts = {expected_pts, map_to_disk(s_tdata[FRAC_BITS-1:0],
					s_tdata[2*FRAC_BITS-1:FRAC_BITS])};
			if (m_tvalid && m_tready) begin
				got = m_tdata[2*OW-1:0];
				if (expected_pts.size() == 0) begin
					report_mismatch("unexpected word, disk_x", got.x, 0);
				end else begin
					want = expected_pts.pop_front();
					if (got.x !== want.x) report_mismatch("disk_x", got.x, want.x);
					if (got.y !== want.y) report_mismatch("disk_y", got.y, want.y);
				end
			end
		end
	end

endmodule

>>> sim/concentric_disk_map_unit_tb.sv
// Testbench top for the concentric disk map unit: drives square points with
// random gaps and back-pressure; the checker predicts and compares.
// Depends on cdm_pkg, concentric_disk_map_unit and concentric_disk_map_checker.
`timescale 1ns / 1ps

module concentric_disk_map_unit_tb;
	localparam int FRAC_BITS = 16;
	localparam int IW = ((2*FRAC_BITS+7)/8)*8;
	localparam int OW = ((2*FRAC_BITS+11)/8)*8;
	localparam int LATENCY = 40;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IW-1:0] s_tdata = '0;  // square_u, square_v
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OW-1:0] m_tdata;       // disk_x, disk_y
	int fail_count, pending;
	int cycles = 0;
	bit quiet = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	concentric_disk_map_unit #(.FRAC_BITS(FRAC_BITS)) u_top (.*);

	concentric_disk_map_checker #(.FRAC_BITS(FRAC_BITS)) u_chk (.*);

	// Give up after a generous cycle count
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Receiver back-pressure: stall in random bursts, none near the end
	always @(negedge clk) begin
		int stall;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			stall = $urandom_range(1, 3);
			m_tready <= 1'b0;
			repeat (stall) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	// Offer one point, hold it until taken; maybe idle afterwards
	task automatic send_point(logic [FRAC_BITS-1:0] u, logic [FRAC_BITS-1:0] v);
		int gap;
		s_tdata <= IW'({v, u});
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	initial begin
		logic [FRAC_BITS-1:0] half, top, zero;
		int k;
		half = FRAC_BITS'(1) << (FRAC_BITS - 1);
		top = '1;
		zero = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Corners, centre, edge midpoints and the sector boundary diagonals
		send_point(half, half);
		send_point(zero, zero);
		send_point(top, zero);
		send_point(zero, top);
		send_point(top, top);
		send_point(half, zero);
		send_point(half, top);
		send_point(zero, half);
		send_point(top, half);
		send_point(FRAC_BITS'(half + 1), half);
		send_point(FRAC_BITS'(half - 1), half);
		send_point(half, FRAC_BITS'(half + 1));
		send_point(half, FRAC_BITS'(half - 1));
		send_point(16'h1234, 16'h1234);
		send_point(16'hC000, 16'h4000);
		send_point(16'h4000, 16'hC000);
		send_point(16'hAAAA, 16'h5555);
		send_point(16'h5555, 16'hAAAA);

		// Hold the sender until every expected word is back
		drain();

		for (k = 0; k < 500; k++) begin
			if (k == 400) quiet = 1'b1;
			case ($urandom_range(0, 3))
				0: begin
					// near a diagonal, where sectors meet
					logic [FRAC_BITS-1:0] a;
					a = FRAC_BITS'($urandom);
					send_point(a, $urandom_range(0, 1)
						? FRAC_BITS'(a + $urandom_range(0, 2) - 1)
						: FRAC_BITS'(~a + $urandom_range(0, 2) - 1));
				end
				1: send_point(FRAC_BITS'(half + $urandom_range(0, 4) - 2),
					FRAC_BITS'(half + $urandom_range(0, 4) - 2));
				default: send_point(FRAC_BITS'($urandom), FRAC_BITS'($urandom));
			endcase
		end

		drain();
		repeat (LATENCY) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
rtl/cdm_pkg.sv
rtl/cdm_div_cell.sv
rtl/cdm_cordic_cell.sv
rtl/concentric_disk_map_unit.sv
sim/concentric_disk_map_checker.sv
sim/concentric_disk_map_unit_tb.sv
